// ===== hw/rtl/xml_token_stream_splitter_assert.svh =====
`ifndef XML_TOKEN_STREAM_SPLITTER_ASSERT_SVH
`define XML_TOKEN_STREAM_SPLITTER_ASSERT_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define XTSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define XTSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/xtss_pkg.sv =====
package xtss_pkg;

	// Characters the lexer reacts to
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// Output queue depth (one request yields at most two results)
	localparam int unsigned QDEPTH = 2;

	typedef enum logic [2:0] {
		KIND_TEXT    = 3'd0,
		KIND_OPEN    = 3'd1,
		KIND_CLOSE   = 3'd2,
		KIND_SELF    = 3'd3,
		KIND_DECL    = 3'd4,
		KIND_COMMENT = 3'd5,
		KIND_EOF     = 3'd6,
		KIND_ERROR   = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_TEXT = 3'b010,
		MODE_TAG  = 3'b100
	} mode_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       byte_valid;
		logic       token_done;
		kind_t      token_kind;
		logic       last_result;
	} result_t;

endpackage

// ===== hw/rtl/xtss_lexer.sv =====
module xtss_lexer
	import xtss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_s1,
	input  logic       eoi_s1,
	input  logic       commit,
	output logic [1:0] res_n,
	output result_t    res0,
	output result_t    res1
);

	mode_t       mode_q, mode_d;
	logic [1:0]  pos_q, pos_d;
	logic [7:0]  tb_q [3];
	logic [7:0]  tb_d [3];
	logic [7:0]  prev_q, prev_d;
	logic        is_drop;
	kind_t       tag_kind;

	assign is_drop = (data_s1 == CH_SPACE) || (data_s1 == CH_TAB) || (data_s1 == CH_CR) ||
		(data_s1 == CH_LF) || (data_s1 == CH_AMP);

	// Tag classification from the first three bytes and the byte before '>'
	always_comb begin
		priority if (tb_q[0] == CH_SLASH) begin
			tag_kind = KIND_CLOSE;
		end else if (prev_q == CH_SLASH) begin
			tag_kind = KIND_SELF;
		end else if (tb_q[0] == CH_QUEST && prev_q == CH_QUEST) begin
			tag_kind = KIND_DECL;
		end else if (tb_q[0] == CH_BANG && tb_q[1] == CH_DASH && tb_q[2] == CH_DASH) begin
			tag_kind = KIND_COMMENT;
		end else if (tb_q[0] == CH_BANG) begin
			tag_kind = KIND_DECL;
		end else begin
			tag_kind = KIND_OPEN;
		end
	end

	// Results and next state for the request in s1
	always_comb begin
		res_n  = 2'd0;
		res0   = '0;
		res1   = '0;
		mode_d = mode_q;
		pos_d  = pos_q;
		tb_d   = tb_q;
		prev_d = prev_q;
		if (eoi_s1) begin
			res0.token_done = 1'b1;
			unique case (mode_q)
				MODE_TEXT: begin
					res0.token_kind = KIND_TEXT;
					res1.token_done = 1'b1;
					res1.token_kind = KIND_EOF;
					res_n = 2'd2;
				end
				MODE_TAG: begin
					res0.token_kind = KIND_ERROR;
					res_n = 2'd1;
				end
				default: begin
					res0.token_kind = KIND_EOF;
					res_n = 2'd1;
				end
			endcase
			mode_d = MODE_IDLE;
			pos_d  = 2'd0;
			tb_d   = '{default: 8'h00};
			prev_d = 8'h00;
		end else begin
			unique case (mode_q)
				MODE_TEXT: begin
					if (data_s1 == CH_LT) begin
						// text ends, then the '<' opens a tag
						res0.token_done = 1'b1;
						res0.token_kind = KIND_TEXT;
						res1.byte_out   = data_s1;
						res1.byte_valid = 1'b1;
						res_n  = 2'd2;
						mode_d = MODE_TAG;
						pos_d  = 2'd0;
						tb_d   = '{default: 8'h00};
						prev_d = CH_LT;
					end else begin
						res0.byte_out   = data_s1;
						res0.byte_valid = 1'b1;
						res_n  = 2'd1;
						prev_d = data_s1;
					end
				end
				MODE_TAG: begin
					res0.byte_out   = data_s1;
					res0.byte_valid = 1'b1;
					res_n  = 2'd1;
					prev_d = data_s1;
					if (data_s1 == CH_GT) begin
						res0.token_done = 1'b1;
						res0.token_kind = tag_kind;
						mode_d = MODE_IDLE;
						pos_d  = 2'd0;
					end else if (pos_q != 2'd3) begin
						tb_d[pos_q] = data_s1;
						pos_d = pos_q + 2'd1;
					end
				end
				default: begin
					// idle, and any unused mode code
					mode_d = MODE_IDLE;
					if (!is_drop) begin
						res0.byte_out   = data_s1;
						res0.byte_valid = 1'b1;
						res_n = 2'd1;
						if (data_s1 == CH_LT) begin
							mode_d = MODE_TAG;
							pos_d  = 2'd0;
							tb_d   = '{default: 8'h00};
							prev_d = CH_LT;
						end else begin
							mode_d = MODE_TEXT;
							prev_d = data_s1;
						end
					end
				end
			endcase
		end
		// mark the final result of this request
		if (res_n == 2'd2) begin
			res1.last_result = 1'b1;
		end else if (res_n == 2'd1) begin
			res0.last_result = 1'b1;
		end
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= 2'd0;
			tb_q   <= '{default: 8'h00};
			prev_q <= 8'h00;
		end else if (commit) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			tb_q   <= tb_d;
			prev_q <= prev_d;
		end
	end

endmodule

// ===== hw/rtl/xtss_out_queue.sv =====
module xtss_out_queue
	import xtss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    push0,
	input  result_t    push1,
	input  logic       pop,
	output logic [1:0] free_slots,
	output logic       head_valid,
	output result_t    head
);

	localparam logic [1:0] DEPTH_L = 2'(QDEPTH);

	result_t    ent_q [QDEPTH];
	result_t    ent_d [QDEPTH];
	logic [1:0] cnt_q, cnt_d, cnt_b;

	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[0];
	// room for this cycle's pushes, counting the entry popped now
	assign free_slots = DEPTH_L - cnt_q + {1'b0, pop};

	// Shift out the popped head, then append the new results
	always_comb begin
		ent_d = ent_q;
		if (pop) begin
			ent_d[0] = ent_q[1];
		end
		cnt_b = cnt_q - {1'b0, pop};
		if (push_n != 2'd0) begin
			ent_d[cnt_b[0]] = push0;
		end
		if (push_n == 2'd2) begin
			ent_d[1] = push1;
		end
		cnt_d = cnt_b + push_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

// ===== hw/rtl/xml_token_stream_splitter.sv =====
// Flow: a request accepted into s1 is scanned there; with an empty output queue it
//   commits at once, and its first result is registered as the queue head.
// Throughput: one byte per cycle while the queue has room; a byte that ends a text
//   token (or end of input in text) yields two results for the single-result port.
// Reset: arst_n clears scan mode, tag history, the input stage and the output queue.
module xml_token_stream_splitter
	import xtss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_out,
	output logic       byte_valid,
	output logic       token_done,
	output logic [2:0] token_kind,
	output logic       last_result
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eoi_s1;
	logic [1:0] res_n, free_slots;
	result_t    res0, res1, head;
	logic       commit, pop, accept;

	// s1 commits once the queue has room for all of its results
	assign commit   = valid_s1 && (free_slots >= res_n);
	assign in_stall = valid_s1 && !commit;
	assign accept   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	xtss_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.data_s1 (data_s1),
		.eoi_s1  (eoi_s1),
		.commit  (commit),
		.res_n   (res_n),
		.res0    (res0),
		.res1    (res1)
	);

	xtss_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (commit ? res_n : 2'd0),
		.push0      (res0),
		.push1      (res1),
		.pop        (pop),
		.free_slots (free_slots),
		.head_valid (out_valid),
		.head       (head)
	);

	assign byte_out    = head.byte_out;
	assign byte_valid  = head.byte_valid;
	assign token_done  = head.token_done;
	assign token_kind  = head.token_kind;
	assign last_result = head.last_result;

endmodule

// ===== hw/rtl/xtss_checker.sv =====
`include "xml_token_stream_splitter_assert.svh"

module xtss_checker
	import xtss_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] byte_out,
	input logic       byte_valid,
	input logic       token_done,
	input logic [2:0] token_kind,
	input logic       last_result
);

	// a stalled result stays offered
	`XTSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	// a result without a byte is always a token end
	`XTSS_ASSERT_NOW(a_nobyte_done, out_valid && !byte_valid, token_done && byte_out == 8'h00, "empty result that ends no token")
	// end-of-file and error close out their request
	`XTSS_ASSERT_NOW(a_eof_last, out_valid && token_done && (token_kind == KIND_EOF || token_kind == KIND_ERROR), last_result, "eof or error not last")
	// kind is only reported with token_done
	`XTSS_ASSERT_NOW(a_kind_zero, out_valid && !token_done, token_kind == KIND_TEXT, "kind without token end")

endmodule

bind xml_token_stream_splitter xtss_checker u_xtss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.byte_out    (byte_out),
	.byte_valid  (byte_valid),
	.token_done  (token_done),
	.token_kind  (token_kind),
	.last_result (last_result)
);

// ===== dv/testbench.sv =====
module testbench;
	import xtss_pkg::*;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS  = 670;

	typedef enum int unsigned {
		SHAPE_OPEN,
		SHAPE_CLOSE,
		SHAPE_SELF,
		SHAPE_QUEST,
		SHAPE_COMMENT,
		SHAPE_BANG,
		SHAPE_EMPTY
	} tag_shape_t;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte    = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] byte_out;
	logic       byte_valid;
	logic       token_done;
	logic [2:0] token_kind;
	logic       last_result;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Mirrors the lexer state and queues the token results each request causes
	class xml_token_tracker;
		mode_t       mode;
		logic [1:0]  tag_pos;
		logic [7:0]  tag_head [3];
		logic [7:0]  last_byte;
		result_t     awaited [$];
		int unsigned errors;
		int unsigned productive;

		function void clear();
			mode      = MODE_IDLE;
			tag_pos   = '0;
			tag_head  = '{default: 8'h00};
			last_byte = 8'h00;
		endfunction

		function void post(logic [7:0] b, logic bv, logic done, kind_t kind, logic last);
			result_t r;
			r.byte_out    = b;
			r.byte_valid  = bv;
			r.token_done  = done;
			r.token_kind  = kind;
			r.last_result = last;
			awaited.push_back(r);
		endfunction

		function void enter_tag();
			mode      = MODE_TAG;
			tag_pos   = '0;
			tag_head  = '{default: 8'h00};
			last_byte = CH_LT;
		endfunction

		// Kind from the first three bytes after '<' and the byte before '>'
		function kind_t tag_kind();
			if (tag_head[0] == CH_SLASH)
				return KIND_CLOSE;
			if (last_byte == CH_SLASH)
				return KIND_SELF;
			if (tag_head[0] == CH_QUEST && last_byte == CH_QUEST)
				return KIND_DECL;
			if (tag_head[0] == CH_BANG && tag_head[1] == CH_DASH && tag_head[2] == CH_DASH)
				return KIND_COMMENT;
			if (tag_head[0] == CH_BANG)
				return KIND_DECL;
			return KIND_OPEN;
		endfunction

		function void take_byte(logic [7:0] c, logic eoi);
			int unsigned depth;
			depth = awaited.size();
			if (eoi) begin
				case (mode)
					MODE_TEXT: begin
						post(8'h00, 1'b0, 1'b1, KIND_TEXT, 1'b0);
						post(8'h00, 1'b0, 1'b1, KIND_EOF, 1'b1);
					end
					MODE_TAG: post(8'h00, 1'b0, 1'b1, KIND_ERROR, 1'b1);
					default:  post(8'h00, 1'b0, 1'b1, KIND_EOF, 1'b1);
				endcase
				clear();
			end else if (mode == MODE_TEXT) begin
				if (c == CH_LT) begin
					// text ends without a byte, then '<' opens the tag
					post(8'h00, 1'b0, 1'b1, KIND_TEXT, 1'b0);
					enter_tag();
				end else begin
					last_byte = c;
				end
				post(c, 1'b1, 1'b0, KIND_TEXT, 1'b1);
			end else if (mode == MODE_TAG) begin
				if (c == CH_GT) begin
					post(c, 1'b1, 1'b1, tag_kind(), 1'b1);
					mode    = MODE_IDLE;
					tag_pos = '0;
				end else begin
					if (tag_pos != 2'd3) begin
						tag_head[tag_pos] = c;
						tag_pos++;
					end
					post(c, 1'b1, 1'b0, KIND_TEXT, 1'b1);
				end
				last_byte = c;
			end else begin
				// between tokens: whitespace and '&' vanish
				if (c == CH_LT) begin
					enter_tag();
					post(c, 1'b1, 1'b0, KIND_TEXT, 1'b1);
				end else if (!(c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_AMP})) begin
					mode      = MODE_TEXT;
					last_byte = c;
					post(c, 1'b1, 1'b0, KIND_TEXT, 1'b1);
				end
			end
			if (awaited.size() != depth)
				productive++;
		endfunction

		function void flag(string field, logic [7:0] want, logic [7:0] seen);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
			errors++;
		endfunction

		function void match_result(result_t seen);
			result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, seen);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (seen.byte_out !== want.byte_out)
				flag("byte_out", want.byte_out, seen.byte_out);
			if (seen.byte_valid !== want.byte_valid)
				flag("byte_valid", 8'(want.byte_valid), 8'(seen.byte_valid));
			if (seen.token_done !== want.token_done)
				flag("token_done", 8'(want.token_done), 8'(seen.token_done));
			if (seen.token_kind !== want.token_kind)
				flag("token_kind", 8'(want.token_kind), 8'(seen.token_kind));
			if (seen.last_result !== want.last_result)
				flag("last_result", 8'(want.last_result), 8'(seen.last_result));
		endfunction
	endclass

	xml_token_tracker tracker = new();

	xml_token_stream_splitter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_out     (byte_out),
		.byte_valid   (byte_valid),
		.token_done   (token_done),
		.token_kind   (token_kind),
		.last_result  (last_result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver backpressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Both channels sampled with the values that held just before the edge
	always @(posedge clk) begin
		result_t seen;
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_byte(data_byte, end_of_input);
			if (out_valid && !out_stall) begin
				seen.byte_out    = byte_out;
				seen.byte_valid  = byte_valid;
				seen.token_done  = token_done;
				seen.token_kind  = kind_t'(token_kind);
				seen.last_result = last_result;
				tracker.match_result(seen);
			end
		end
	end

	// Watchdog on cycles with no request or result moving
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// One request; returns at the edge where it is accepted
	task automatic send_request(input logic [7:0] b, input logic eoi);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], 1'b0);
	endtask

	// Random bytes that never equal the terminator of the current token
	task automatic send_filler(input int unsigned n, input logic [7:0] stop);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(255));
			if (b == stop)
				b = b ^ 8'h01;
			send_request(b, 1'b0);
		end
	endtask

	task automatic send_tag();
		tag_shape_t shape;
		shape = tag_shape_t'($urandom_range(6));
		send_request(CH_LT, 1'b0);
		case (shape)
			SHAPE_OPEN: send_filler($urandom_range(0, 5), CH_GT);
			SHAPE_CLOSE: begin
				send_request(CH_SLASH, 1'b0);
				send_filler($urandom_range(0, 5), CH_GT);
			end
			SHAPE_SELF: begin
				send_filler($urandom_range(0, 5), CH_GT);
				send_request(CH_SLASH, 1'b0);
			end
			SHAPE_QUEST: begin
				send_request(CH_QUEST, 1'b0);
				send_filler($urandom_range(0, 4), CH_GT);
				send_request(CH_QUEST, 1'b0);
			end
			SHAPE_COMMENT: begin
				send_request(CH_BANG, 1'b0);
				send_request(CH_DASH, 1'b0);
				send_request(CH_DASH, 1'b0);
				send_filler($urandom_range(0, 4), CH_GT);
			end
			SHAPE_BANG: begin
				send_request(CH_BANG, 1'b0);
				send_filler($urandom_range(0, 5), CH_GT);
			end
			default: ;
		endcase
		// now and then the document ends inside the tag
		if ($urandom_range(19) == 0)
			send_request(8'($urandom_range(255)), 1'b1);
		else
			send_request(CH_GT, 1'b0);
	endtask

	// Mostly well-formed markup with random content, some noise and early ends
	task automatic send_document_stream(input int unsigned target);
		logic [7:0]  blanks [5];
		int unsigned pick;
		blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_AMP};
		while (tracker.productive < target) begin
			pick = $urandom_range(99);
			if (pick < 45)
				send_tag();
			else if (pick < 75)
				send_filler($urandom_range(1, 6), CH_LT);
			else if (pick < 85)
				send_request(blanks[3'($urandom_range(4))], 1'b0);
			else if (pick < 92)
				send_request(8'($urandom_range(255)), 1'b1);
			else
				send_request(8'($urandom_range(255)), 1'b0);
		end
	endtask

	initial begin
		tracker.clear();
		send_idle_pct  = 29;
		recv_stall_pct = 80;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: dropped bytes, byte extremes, every tag kind, each end of input
		send_string(" \t\r\n&");
		send_request(8'h00, 1'b0);
		send_request(8'hFF, 1'b0);
		send_string("<>");
		send_string("</>");
		send_string("<?>");
		send_string("<!-->");
		send_string("<a/>");
		send_request(8'hFF, 1'b1);
		send_request(8'h78, 1'b0);
		send_request(8'h00, 1'b1);
		send_request(CH_LT, 1'b0);
		send_request(8'hA5, 1'b1);

		// Random phases with shifting backpressure
		send_document_stream(tracker.productive + PHASE_ITEMS);
		send_idle_pct  = 80;
		recv_stall_pct = 29;
		send_document_stream(tracker.productive + PHASE_ITEMS);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_document_stream(tracker.productive + PHASE_ITEMS);
		send_request(8'($urandom_range(255)), 1'b1);

		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
